>>> hw/rtl/i2cbr_pkg.sv
// ----------------------------------------------------------------------------
// I2C register block reader package
// Command codes, register indexes and sizing constants used by the reader;
// its channel interfaces declare matching fields of their own.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbr_pkg;

	// Host buffer depth; the block length saturates to this.
	localparam int BUFFER_DEPTH = 32;

	// Width of the length compare (byte count plus one bit of headroom).
	localparam int LEN_W = 7;

	// Peripheral commands issued by the sequencer.
	typedef enum logic [2:0] {
		CMD_NONE       = 3'd0,
		CMD_RESET_STOP = 3'd1,
		CMD_START      = 3'd2,
		CMD_TRANSMIT   = 3'd3,
		CMD_RECEIVE    = 3'd4,
		CMD_ACK        = 3'd5,
		CMD_STOP       = 3'd6
	} cmd_t;

	// Configuration register indexes (word address).
	typedef enum logic [1:0] {
		REG_DEVICE_ADDRESS   = 2'd0,
		REG_REGISTER_ADDRESS = 2'd1,
		REG_BYTE_COUNT       = 2'd2,
		REG_UNUSED           = 2'd3
	} reg_idx_t;

	// Acknowledge bit values carried in data_byte.
	localparam logic [7:0] ACK_BIT  = 8'd0;
	localparam logic [7:0] NACK_BIT = 8'd1;

	// Register reset values.
	localparam logic [6:0] DEVICE_ADDRESS_RST   = 7'd0;
	localparam logic [7:0] REGISTER_ADDRESS_RST = 8'd0;
	localparam logic [5:0] BYTE_COUNT_RST       = 6'd1;

	// One poll of the peripheral status.
	typedef struct packed {
		logic       restart;
		logic       start_busy;
		logic       stop_busy;
		logic       receive_busy;
		logic       ack_busy;
		logic       transmit_active;
		logic       write_collision;
		logic [7:0] rx_byte;
	} poll_t;

	// One result of the sequencer.
	typedef struct packed {
		logic [2:0] command;
		logic [7:0] data_byte;
		logic       clear_collision;
		logic       store_valid;
		logic [4:0] store_index;
		logic [7:0] store_byte;
		logic       done_res;
	} result_t;

endpackage

`default_nettype wire

>>> hw/rtl/i2cbr_in_if.sv
// ----------------------------------------------------------------------------
// I2C register block reader poll channel
// Valid/ready channel that carries one peripheral status poll.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cbr_in_if;
	logic       valid;
	logic       ready;
	logic       restart;
	logic       start_busy;
	logic       stop_busy;
	logic       receive_busy;
	logic       ack_busy;
	logic       transmit_active;
	logic       write_collision;
	logic [7:0] rx_byte;

	modport source (
		output valid, restart, start_busy, stop_busy, receive_busy, ack_busy,
		       transmit_active, write_collision, rx_byte,
		input  ready
	);

	modport sink (
		input  valid, restart, start_busy, stop_busy, receive_busy, ack_busy,
		       transmit_active, write_collision, rx_byte,
		output ready
	);
endinterface

`default_nettype wire

>>> hw/rtl/i2cbr_out_if.sv
// ----------------------------------------------------------------------------
// I2C register block reader result channel
// Valid/ready channel that carries one peripheral command and buffer store.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cbr_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [7:0] data_byte;
	logic       clear_collision;
	logic       store_valid;
	logic [4:0] store_index;
	logic [7:0] store_byte;
	logic       done_res;

	modport source (
		output valid, command, data_byte, clear_collision, store_valid,
		       store_index, store_byte, done_res,
		input  ready
	);

	modport sink (
		input  valid, command, data_byte, clear_collision, store_valid,
		       store_index, store_byte, done_res,
		output ready
	);
endinterface

`default_nettype wire

>>> hw/rtl/i2c_register_block_reader_unit.sv
// ----------------------------------------------------------------------------
// I2C register block reader
// Path: an accepted poll is held in the input register, and its result is
// then held in the result register. Throughput: one poll per cycle while
// the result channel takes each result, set by the single step of the
// sequencer taken between the two registers.
// Reset: arst_n clears the sequencer to step 0, the byte index to 0, both
// channel registers to empty and the configuration registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_register_block_reader_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	i2cbr_in_if.sink         req,
	i2cbr_out_if.source      rsp
);

	// Sequencer steps.
	typedef enum logic [3:0] {
		ST_START      = 4'd0,
		ST_DEV_WR     = 4'd1,
		ST_COLL_CHECK = 4'd2,
		ST_SLAVE_ACK  = 4'd3,
		ST_REG_ADDR   = 4'd4,
		ST_RESTART    = 4'd5,
		ST_DEV_RD     = 4'd6,
		ST_RECV_FIRST = 4'd7,
		ST_STORE_ACK  = 4'd8,
		ST_RECV_NEXT  = 4'd9,
		ST_STOP       = 4'd10,
		ST_DONE       = 4'd11
	} step_t;

	// Configuration registers.
	logic [6:0] device_address_q;
	logic [7:0] register_address_q;
	logic [5:0] byte_count_q;

	// Sequencer state.
	step_t      step_q;
	logic [5:0] byte_index_q;

	// Input stage and result stage.
	logic                 valid_s1;
	i2cbr_pkg::poll_t     poll_s1;
	logic                 valid_s2;
	i2cbr_pkg::result_t   res_s2;

	// Next-state logic outputs.
	step_t                step_d;
	logic [5:0]           byte_index_d;
	i2cbr_pkg::result_t   res_d;

	logic                    advance;
	logic                    busy;
	logic [i2cbr_pkg::LEN_W-1:0] eff_len;
	logic [5:0]              index_inc;
	i2cbr_pkg::reg_idx_t     wr_idx;
	logic                    cfg_write;

	// APB access: always ready, write on the access phase.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign wr_idx    = i2cbr_pkg::reg_idx_t'(paddr[3:2]);

	always_comb begin
		unique case (wr_idx)
			i2cbr_pkg::REG_DEVICE_ADDRESS:   prdata = {25'd0, device_address_q};
			i2cbr_pkg::REG_REGISTER_ADDRESS: prdata = {24'd0, register_address_q};
			i2cbr_pkg::REG_BYTE_COUNT:       prdata = {26'd0, byte_count_q};
			default:                         prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q   <= i2cbr_pkg::DEVICE_ADDRESS_RST;
			register_address_q <= i2cbr_pkg::REGISTER_ADDRESS_RST;
			byte_count_q       <= i2cbr_pkg::BYTE_COUNT_RST;
		end else if (cfg_write) begin
			unique case (wr_idx)
				i2cbr_pkg::REG_DEVICE_ADDRESS:   device_address_q   <= pwdata[6:0];
				i2cbr_pkg::REG_REGISTER_ADDRESS: register_address_q <= pwdata[7:0];
				i2cbr_pkg::REG_BYTE_COUNT:       byte_count_q       <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	// Handshakes: the input register moves on when the result register is
	// free or is being emptied in the same cycle.
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// Block length: a zero count reads one byte, and the length saturates
	// at the buffer depth.
	always_comb begin
		eff_len = {1'b0, byte_count_q};
		if (byte_count_q == 6'd0) begin
			eff_len = i2cbr_pkg::LEN_W'(1);
		end
		if (eff_len > i2cbr_pkg::LEN_W'(i2cbr_pkg::BUFFER_DEPTH)) begin
			eff_len = i2cbr_pkg::LEN_W'(i2cbr_pkg::BUFFER_DEPTH);
		end
	end

	assign index_inc = byte_index_q + 6'd1;
	assign busy = poll_s1.start_busy || poll_s1.stop_busy || poll_s1.receive_busy
		|| poll_s1.ack_busy || poll_s1.transmit_active;

	// One sequencer step for the poll held in the input register.
	always_comb begin
		res_d        = '0;
		res_d.command = i2cbr_pkg::CMD_NONE;
		step_d       = step_q;
		byte_index_d = byte_index_q;
		priority if (poll_s1.restart) begin
			res_d.command = i2cbr_pkg::CMD_RESET_STOP;
			step_d        = ST_START;
			byte_index_d  = 6'd0;
		end else if (busy) begin
			res_d.done_res = (step_q == ST_DONE);
		end else begin
			unique case (step_q)
				ST_START: begin
					res_d.command = i2cbr_pkg::CMD_START;
					step_d        = ST_DEV_WR;
				end
				ST_DEV_WR: begin
					res_d.command   = i2cbr_pkg::CMD_TRANSMIT;
					res_d.data_byte = {device_address_q, 1'b0};
					step_d          = ST_COLL_CHECK;
				end
				ST_COLL_CHECK: begin
					// A collision on the first address starts the sequence over.
					if (poll_s1.write_collision) begin
						res_d.clear_collision = 1'b1;
						step_d                = ST_START;
					end else begin
						step_d = ST_SLAVE_ACK;
					end
				end
				ST_SLAVE_ACK: begin
					step_d = ST_REG_ADDR;
				end
				ST_REG_ADDR: begin
					res_d.command   = i2cbr_pkg::CMD_TRANSMIT;
					res_d.data_byte = register_address_q;
					step_d          = ST_RESTART;
				end
				ST_RESTART: begin
					res_d.clear_collision = poll_s1.write_collision;
					res_d.command         = i2cbr_pkg::CMD_START;
					step_d                = ST_DEV_RD;
				end
				ST_DEV_RD: begin
					res_d.command   = i2cbr_pkg::CMD_TRANSMIT;
					res_d.data_byte = {device_address_q, 1'b1};
					step_d          = ST_RECV_FIRST;
				end
				ST_RECV_FIRST, ST_RECV_NEXT: begin
					res_d.clear_collision = poll_s1.write_collision;
					res_d.command         = i2cbr_pkg::CMD_RECEIVE;
					step_d                = ST_STORE_ACK;
				end
				ST_STORE_ACK: begin
					// Store the byte, then ack it, or nack it if it is the last.
					res_d.store_valid = 1'b1;
					res_d.store_index = byte_index_q[4:0];
					res_d.store_byte  = poll_s1.rx_byte;
					res_d.command     = i2cbr_pkg::CMD_ACK;
					byte_index_d      = index_inc;
					if ({1'b0, index_inc} >= eff_len) begin
						res_d.data_byte = i2cbr_pkg::NACK_BIT;
						step_d          = ST_STOP;
					end else begin
						res_d.data_byte = i2cbr_pkg::ACK_BIT;
						step_d          = ST_RECV_NEXT;
					end
				end
				ST_STOP: begin
					res_d.command = i2cbr_pkg::CMD_STOP;
					step_d        = ST_DONE;
				end
				ST_DONE: begin
					res_d.done_res = 1'b1;
				end
				default: begin
					step_d = ST_START;
				end
			endcase
		end
	end

	// Sequencer state, input register and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= ST_START;
			byte_index_q <= 6'd0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			poll_s1      <= '0;
			res_s2       <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
				poll_s1  <= {req.restart, req.start_busy, req.stop_busy,
					req.receive_busy, req.ack_busy, req.transmit_active,
					req.write_collision, req.rx_byte};
			end
			if (advance) begin
				step_q       <= step_d;
				byte_index_q <= byte_index_d;
				res_s2       <= res_d;
				valid_s2     <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Result channel.
	assign rsp.valid           = valid_s2;
	assign rsp.command         = res_s2.command;
	assign rsp.data_byte       = res_s2.data_byte;
	assign rsp.clear_collision = res_s2.clear_collision;
	assign rsp.store_valid     = res_s2.store_valid;
	assign rsp.store_index     = res_s2.store_index;
	assign rsp.store_byte      = res_s2.store_byte;
	assign rsp.done_res        = res_s2.done_res;

endmodule

`default_nettype wire
